// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
		else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
		else $error(msg);

`else

`define ASSERT_PROP(lbl, clk_i, rstn_i, prop, msg)
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg)

`endif

`endif

// ----- hw/rtl/trp_pkg.sv -----
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types for the transmit ring packetizer.
// ----------------------------------------------------------------------------
package trp_pkg;

	// Input beat kinds carried on the slave-side tuser.
	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POLL = 2'd1,
		KIND_ARM  = 2'd2
	} kind_t;

	// Sequencer states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

// ----- hw/rtl/tx_ring_packetizer.sv -----
// ----------------------------------------------------------------------------
// tx_ring_packetizer
// Transmit byte ring that drains into short packets with empty-packet end.
// ----------------------------------------------------------------------------
// Input beats carry a kind on tuser: push appends the tdata byte to a ring of
// DEPTH bytes (at most DEPTH-1 held; a push into a full ring is dropped), arm
// sets the empty-packet pending flag, and a ready poll drains the bytes lying
// contiguously from the read pointer up to the write pointer or the ring wrap,
// at most MAX_PACKET, as one packet with tlast on its final beat. A poll that
// finds the ring empty with the flag pending emits one beat with tuser (empty
// packet) and tlast high and tdata zero; a poll with nothing to send emits
// nothing. After a packet the flag is set exactly when a full MAX_PACKET
// packet emptied the ring. A draining poll holds the input side until its
// final byte has left the read stage: the ring is one synchronous memory with
// a single read port, so the drain reads one byte a cycle while the master
// side takes beats, each byte passing the registered read stage and then the
// output register. An empty-packet poll holds the input until its marker has
// left the read stage. Back-pressure on the master side stretches the drain
// beat by beat. The output register lets the next input beat in while the
// last result still waits to be taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tx_ring_packetizer #(
	parameter int DEPTH      = 256,
	parameter int MAX_PACKET = 8
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
	input  logic [1:0] s_axis_tuser,   // [1:0] kind

	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic       m_axis_tlast,   // last
	output logic       m_axis_tuser    // [0] empty_packet
);

	import trp_pkg::*;

	// Pointer width, packet count width, and a width wide enough for both.
	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(MAX_PACKET + 1);
	localparam int CW = (PW + 1 > LW) ? PW + 1 : LW;

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	state_t          state_q;
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic            pending_q;
	logic [LW-1:0]   cnt_q;        // bytes of the packet still to read

	// Read stage: registered memory data or an empty-packet marker.
	logic            rd_vld_s1;
	logic [7:0]      rd_data_s1;
	logic            rd_last_s1;
	logic            rd_empty_s1;

	// Output register.
	logic            out_valid_q;
	logic [7:0]      out_data_q;
	logic            out_last_q;
	logic            out_empty_q;

	logic [7:0]      ring_mem [DEPTH];

	// ------------------------------------------------------------------
	// Decode of the accepted beat
	// ------------------------------------------------------------------
	logic            in_acc;
	logic            do_push;
	logic            do_poll;
	logic            do_arm;
	logic [PW-1:0]   wr_next;
	logic [PW-1:0]   rd_next;
	logic            ring_full;
	logic            ring_empty;
	logic [CW-1:0]   len_raw;
	logic [CW-1:0]   len_cl;
	logic [CW-1:0]   end_sum;
	logic            drains_all;
	logic            start_drain;
	logic            load_zlp;
	logic            out_free;
	logic            s1_move;
	logic            rd_issue;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		do_push = 1'b0;
		do_poll = 1'b0;
		do_arm  = 1'b0;
		case (kind_t'(s_axis_tuser))
			KIND_PUSH: begin
				do_push = in_acc;
			end
			KIND_POLL: begin
				do_poll = in_acc;
			end
			KIND_ARM: begin
				do_arm = in_acc;
			end
			default: begin
				// unused kind: ignore the beat
			end
		endcase
	end

	// Wrap both pointers at DEPTH-1, which need not be a power of two.
	assign wr_next    = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
	assign rd_next    = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign ring_full  = (wr_next == rd_q);
	assign ring_empty = (wr_q == rd_q);

	// Contiguous run up to the write pointer or the ring wrap, capped.
	assign len_raw = (wr_q >= rd_q) ? CW'(wr_q) - CW'(rd_q)
	                                : CW'(DEPTH) - CW'(rd_q);
	assign len_cl  = (len_raw > CW'(MAX_PACKET)) ? CW'(MAX_PACKET) : len_raw;

	// Does this packet leave the read pointer on the write pointer?
	assign end_sum    = CW'(rd_q) + len_cl;
	assign drains_all = (end_sum == CW'(wr_q)) ||
	                    ((end_sum == CW'(DEPTH)) && (wr_q == '0));

	assign start_drain = do_poll && !ring_empty;
	assign load_zlp    = do_poll && ring_empty && pending_q;

	// Pipeline movement: s1 advances into the output register when that
	// register is empty or being emptied; a read issues while s1 can take it.
	assign out_free = !out_valid_q || m_axis_tready;
	assign s1_move  = rd_vld_s1 && out_free;
	assign rd_issue = (state_q == ST_DRAIN) && (cnt_q != '0) &&
	                  (!rd_vld_s1 || out_free);

	// Pushes are only taken in idle, so a write never meets a drain read.
	assign s_axis_tready = (state_q == ST_IDLE) && !rd_vld_s1;

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_q        <= '0;
			rd_q        <= '0;
			pending_q   <= 1'b0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// advance the write pointer unless the ring is full (drop)
			if (do_push && !ring_full) begin
				wr_q <= wr_next;
			end
			if (do_arm) begin
				pending_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (start_drain) begin
						state_q   <= ST_DRAIN;
						cnt_q     <= LW'(len_cl);
						pending_q <= (len_cl == CW'(MAX_PACKET)) && drains_all;
					end else if (load_zlp) begin
						pending_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					if (rd_issue) begin
						cnt_q <= cnt_q - 1'b1;
						rd_q  <= rd_next;
					end
					// back to idle once the final byte has left s1
					if ((cnt_q == '0) && (!rd_vld_s1 || out_free)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (rd_issue || load_zlp) begin
				rd_vld_s1 <= 1'b1;
			end else if (s1_move) begin
				rd_vld_s1 <= 1'b0;
			end

			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Ring memory: one write port, one registered read port
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (do_push && !ring_full) begin
			ring_mem[wr_q] <= s_axis_tdata;
		end
		if (rd_issue) begin
			rd_data_s1 <= ring_mem[rd_q];
		end else if (load_zlp) begin
			rd_data_s1 <= '0;
		end
	end

	// Payload flags of the read stage and the output register.
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_last_s1  <= (cnt_q == LW'(1));
			rd_empty_s1 <= 1'b0;
		end else if (load_zlp) begin
			rd_last_s1  <= 1'b1;
			rd_empty_s1 <= 1'b1;
		end
		if (s1_move) begin
			out_data_q  <= rd_data_s1;
			out_last_q  <= rd_last_s1;
			out_empty_q <= rd_empty_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_empty_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_PROP(a_zlp_form, clk, arst_n,
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0),
		"empty packet beat without last or with nonzero data")
	`ASSERT_NEVER(a_no_overread, clk, arst_n,
		(state_q == ST_DRAIN) && (cnt_q != '0) && (rd_q == wr_q),
		"drain reads past the write pointer")
	`ASSERT_PROP(a_idle_count, clk, arst_n,
		(state_q == ST_IDLE) |-> (cnt_q == '0),
		"packet count left over in idle")
	`ASSERT_PROP(a_s1_hold, clk, arst_n,
		rd_vld_s1 && !out_free |=> rd_vld_s1 && $stable(rd_data_s1),
		"read stage lost or changed a stalled byte")

endmodule

// ----- sim/tx_ring_packetizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tx_ring_packetizer_tb
// Self-checking bench for the transmit ring packetizer.
// ----------------------------------------------------------------------------
// Drive push, poll, arm and unused beats on the slave stream. Run a short table
// of directed beats first, then random traffic and one fill of the ring past
// full. Check every master beat against its table row or the bench ring model.
// ----------------------------------------------------------------------------
module tx_ring_packetizer_tb;
	import trp_pkg::*;

	localparam int RING_DEPTH = 256;
	localparam int PKT_MAX    = 8;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// One packet beat as seen on the master side.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       zlp;
	} pkt_beat_t;

	// One directed row; when fixed is set, has_beat and beat give the answer.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       fixed;
		logic       has_beat;
		pkt_beat_t  beat;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       m_axis_tuser;

	// Ring model state.
	logic [7:0] ring_mem [0:RING_DEPTH-1];
	logic [7:0] wr_idx;
	logic [7:0] rd_idx;
	logic       zlp_pending;

	pkt_beat_t  poll_beats[$];     // beats caused by the latest input beat
	pkt_beat_t  expected_beats[$]; // beats still owed by the block

	int unsigned src_idle;
	int unsigned dst_idle;
	int unsigned errors;
	int unsigned items_sent;
	int unsigned beats_checked;
	int unsigned zlp_checked;
	int unsigned pushes_dropped;

	// Directed table: extremes of the byte, every kind, empty packets and the
	// pending flag set by a full packet that empties the ring.
	stim_row_t dir_table [0:23] = '{
		'{KIND_POLL,   8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}}, // nothing to send
		'{KIND_UNUSED, 8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}}, // ignored kind
		'{KIND_ARM,    8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_POLL,   8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}, // empty packet
		'{KIND_POLL,   8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}}, // flag consumed
		'{KIND_PUSH,   8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_POLL,   8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
		'{KIND_PUSH,   8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_POLL,   8'h00, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
		'{KIND_PUSH,   8'hA5, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_PUSH,   8'h5A, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_PUSH,   8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_PUSH,   8'h80, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_PUSH,   8'h7F, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_PUSH,   8'hFE, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_PUSH,   8'h33, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_PUSH,   8'hCC, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_POLL,   8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}}, // full packet
		'{KIND_POLL,   8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}, // trailing empty
		'{KIND_ARM,    8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_PUSH,   8'h11, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_POLL,   8'h00, 1'b1, 1'b1, '{8'h11, 1'b1, 1'b0}}, // short packet clears flag
		'{KIND_POLL,   8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{KIND_UNUSED, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}}
	};

	tx_ring_packetizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Step the ring model by one input beat; leave the beats it causes in
	// poll_beats.
	function automatic void packetize_beat(input logic [1:0] kind, input logic [7:0] value);
		logic [7:0]  nxt;
		int unsigned span;
		pkt_beat_t   b;
		poll_beats.delete();
		case (kind)
			KIND_PUSH: begin
				nxt = wr_idx + 8'd1;
				// Drop the byte when the ring already holds DEPTH-1 bytes.
				if (nxt != rd_idx) begin
					ring_mem[wr_idx] = value;
					wr_idx = nxt;
				end else begin
					pushes_dropped++;
				end
			end
			KIND_ARM: begin
				zlp_pending = 1'b1;
			end
			KIND_POLL: begin
				if (wr_idx != rd_idx || zlp_pending) begin
					// Drain only up to the wrap of the ring.
					span = (wr_idx >= rd_idx) ? int'(wr_idx) - int'(rd_idx)
						: RING_DEPTH - int'(rd_idx);
					if (span > PKT_MAX)
						span = PKT_MAX;
					if (span == 0) begin
						b = '{8'h00, 1'b1, 1'b1};
						poll_beats.push_back(b);
						zlp_pending = 1'b0;
					end else begin
						for (int i = 0; i < span; i++) begin
							b = '{ring_mem[rd_idx + 8'(i)], (i + 1 == span), 1'b0};
							poll_beats.push_back(b);
						end
						rd_idx = rd_idx + 8'(span);
						// Arm the trailing empty packet only when a full packet
						// emptied the ring.
						zlp_pending = (span == PKT_MAX) && (wr_idx == rd_idx);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Offer one input beat from a falling edge, hold it until accepted, and
	// return at the next falling edge with tvalid still high.
	task automatic send_beat(input logic [1:0] kind, input logic [7:0] value,
		input logic fixed, input logic has_beat, input pkt_beat_t beat);
		while ($urandom_range(0, 99) < src_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = value;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		packetize_beat(kind, value);
		if (fixed) begin
			if (has_beat)
				expected_beats.push_back(beat);
		end else begin
			foreach (poll_beats[i])
				expected_beats.push_back(poll_beats[i]);
		end
		@(negedge clk);
	endtask

	task automatic send_random(input int unsigned count);
		int unsigned r;
		logic [1:0]  kind;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				kind = KIND_PUSH;
			else if (r < 85)
				kind = KIND_POLL;
			else if (r < 95)
				kind = KIND_ARM;
			else
				kind = KIND_UNUSED;
			send_beat(kind, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
		end
	endtask

	// Hold the sender off until every owed beat has come out.
	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: change tready at the falling edge, stalling at random.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = ($urandom_range(0, 99) >= dst_idle);
		end
	end

	// Check each accepted master beat against the oldest owed beat.
	always @(posedge clk) begin
		pkt_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat data=%h last=%b zlp=%b", $time,
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				want = expected_beats.pop_front();
				beats_checked++;
				if (want.zlp)
					zlp_checked++;
				if (m_axis_tdata !== want.data) begin
					errors++;
					$display("%0t: data mismatch, expected %h, got %h", $time,
						want.data, m_axis_tdata);
				end
				if (m_axis_tlast !== want.last) begin
					errors++;
					$display("%0t: tlast mismatch, expected %b, got %b", $time,
						want.last, m_axis_tlast);
				end
				if (m_axis_tuser !== want.zlp) begin
					errors++;
					$display("%0t: empty-packet flag mismatch, expected %b, got %b",
						$time, want.zlp, m_axis_tuser);
				end
			end
		end
	end

	// Main sequence.
	initial begin
		int unsigned fill_count;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = 8'h00;
		s_axis_tuser   = KIND_PUSH;
		wr_idx         = 8'd0;
		rd_idx         = 8'd0;
		zlp_pending    = 1'b0;
		errors         = 0;
		items_sent     = 0;
		beats_checked  = 0;
		zlp_checked    = 0;
		pushes_dropped = 0;
		src_idle       = 19;
		dst_idle       = 49;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table, then random traffic with the sender lighter on gaps.
		foreach (dir_table[i])
			send_beat(dir_table[i].kind, dir_table[i].value, dir_table[i].fixed,
				dir_table[i].has_beat, dir_table[i].beat);
		send_random(55);
		wait_drained();

		// Swap the idle rates; send random traffic, overfill the ring by three bytes, then drain it.
		src_idle = 49;
		dst_idle = 19;
		send_random(55);
		fill_count = (RING_DEPTH - 1) - int'(8'(wr_idx - rd_idx)) + 3;
		for (int n = 0; n < fill_count; n++)
			send_beat(KIND_PUSH, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
		while (wr_idx != rd_idx || zlp_pending)
			send_beat(KIND_POLL, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
		wait_drained();

		// Back to back on both sides.
		src_idle = 0;
		dst_idle = 0;
		send_random(55);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("summary: %0d input beats sent, %0d output beats checked (%0d empty packets)",
			items_sent, beats_checked, zlp_checked);
		$display("summary: %0d pushes dropped on a full ring, %0d mismatches",
			pushes_dropped, errors);
		if (errors == 0 && expected_beats.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- tx_ring_packetizer.f -----
+incdir+hw/rtl
hw/rtl/trp_pkg.sv
hw/rtl/tx_ring_packetizer.sv
sim/tx_ring_packetizer_tb.sv
